// File: src/tbt_pkg.sv
// ----------------------------------------------------------------------------
// Timestamped belief table package
// Table sizes, derived widths, request and status codes, and the helper that
// maps an entry and a verb to a stamp memory address.
// ----------------------------------------------------------------------------
package tbt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int VERBS         = 8;

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int VERB_W = (VERBS > 1) ? $clog2(VERBS) : 1;
    localparam int STAMPS = TABLE_ENTRIES * VERBS;
    localparam int SA_W   = (STAMPS > 1) ? $clog2(STAMPS) : 1;

    typedef enum logic [1:0] {
        REQ_RECORD = 2'd0,
        REQ_QUERY  = 2'd1,
        REQ_MARK   = 2'd2,
        REQ_COMMIT = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_REJECTED = 2'd1,
        ST_INSERTED = 2'd2,
        ST_EVICTED  = 2'd3
    } status_t;

    // Stamps of one entry sit at consecutive addresses.
    function automatic logic [SA_W-1:0] stamp_addr(input logic [IDX_W-1:0] e,
                                                   input logic [VERB_W-1:0] v);
        logic [SA_W-1:0] base;
        base = SA_W'(e) * SA_W'(VERBS);
        return base + SA_W'(v);
    endfunction

endpackage

// File: src/tbt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/timestamped_belief_table.sv
// ----------------------------------------------------------------------------
// Timestamped belief table
// Fully associative table of subject handles with one timestamp per verb,
// oldest-entry eviction, freshness queries and a mark-and-commit sweep.
// ----------------------------------------------------------------------------
//   Channel   Handshake             Payload
//   in        in_valid / in_stall   req_type, subject, verb, now, max_age
//   out       out_valid / out_stall belief_mask, removed_count, status
//   cfg       cfg_we                cfg_data (empty handle)
//
// One sequencer drives a handle RAM and a stamp RAM, one read per step.
// A search reads and compares each stored entry in turn; a query then reads
// each verb's stamp of the slot, an eviction scans every stamp of every entry,
// and a commit checks each entry and moves a marked one's handle and stamps down.
// in_stall is high while an item is in work; a finished result waits in the
// output register and only holds back the next result.
// Reset empties the table at once; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
module timestamped_belief_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [31:0] subject,
    input  logic [7:0]  verb,
    input  logic [31:0] now,
    input  logic [31:0] max_age,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  belief_mask,
    output logic [5:0]  removed_count,
    output logic [1:0]  status
);

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH_RD, S_SRCH_CMP, S_VICT_RD, S_VICT_CMP, S_CLR,
        S_UPD_RD, S_UPD_CMP, S_QRY_RD, S_QRY_CMP, S_CMT_CHK, S_CMT_HRD,
        S_CMT_HWR, S_CMT_SRD, S_CMT_SWR, S_DONE
    } state_t;

    localparam int IW = tbt_pkg::IDX_W;
    localparam int CW = tbt_pkg::CNT_W;
    localparam int VW = tbt_pkg::VERB_W;
    localparam int AW = tbt_pkg::SA_W;

    state_t state_reg, state_next;
    logic [31:0] empty_reg, empty_next;
    logic [1:0]  req_reg, req_next;
    logic [31:0] subj_reg, subj_next;
    logic [VW-1:0] verb_reg, verb_next;
    logic [31:0] now_reg, now_next;
    logic [31:0] age_reg, age_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [VW-1:0] sub_reg, sub_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [IW-1:0] best_reg, best_next;
    logic [31:0] newest_reg, newest_next;
    logic [31:0] oldest_reg, oldest_next;
    logic [CW-1:0] kept_reg, kept_next;
    logic [CW-1:0] count_reg, count_next;
    logic [tbt_pkg::TABLE_ENTRIES-1:0] mark_reg, mark_next;
    logic [7:0]  mask_reg, mask_next;
    logic [5:0]  rem_reg, rem_next;
    logic [1:0]  stat_reg, stat_next;
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  omask_reg, omask_next;
    logic [5:0]  orem_reg, orem_next;
    logic [1:0]  ostat_reg, ostat_next;

    // RAM ports.
    logic          h_we;
    logic [IW-1:0] h_waddr;
    logic [31:0]   h_wdata, h_rdata;
    logic          s_we;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [31:0]   s_wdata, s_rdata;

    // Working values.
    logic [31:0] newest_cur;
    logic        fresh;
    logic        last_verb;
    logic [IW-1:0] idx_lo;

    tbt_ram #(.WIDTH(32), .DEPTH(tbt_pkg::TABLE_ENTRIES), .AW(IW)) u_handle_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (idx_lo),
        .rdata (h_rdata)
    );

    tbt_ram #(.WIDTH(32), .DEPTH(tbt_pkg::STAMPS), .AW(AW)) u_stamp_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    assign idx_lo    = idx_reg[IW-1:0];
    assign last_verb = (sub_reg == VW'(tbt_pkg::VERBS - 1));
    assign newest_cur = (s_rdata > newest_reg) ? s_rdata : newest_reg;

    // A stamp is fresh when set and max_age is zero, or it is from the future or inside the window.
    assign fresh = (s_rdata != 32'd0) &&
                   ((age_reg == 32'd0) || (now_reg < s_rdata) ||
                    ((now_reg - s_rdata) <= age_reg));

    // Handshake outputs.
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = ovalid_reg;
    assign belief_mask   = omask_reg;
    assign removed_count = orem_reg;
    assign status        = ostat_reg;

    // Stamp read address per state.
    always_comb
    begin
        unique case (state_reg)
            S_UPD_RD: s_raddr = tbt_pkg::stamp_addr(slot_reg, verb_reg);
            S_QRY_RD: s_raddr = tbt_pkg::stamp_addr(slot_reg, sub_reg);
            default:  s_raddr = tbt_pkg::stamp_addr(idx_lo, sub_reg);
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        empty_next  = empty_reg;
        req_next    = req_reg;
        subj_next   = subj_reg;
        verb_next   = verb_reg;
        now_next    = now_reg;
        age_next    = age_reg;
        idx_next    = idx_reg;
        sub_next    = sub_reg;
        slot_next   = slot_reg;
        best_next   = best_reg;
        newest_next = newest_reg;
        oldest_next = oldest_reg;
        kept_next   = kept_reg;
        count_next  = count_reg;
        mark_next   = mark_reg;
        mask_next   = mask_reg;
        rem_next    = rem_reg;
        stat_next   = stat_reg;
        ovalid_next = ovalid_reg;
        omask_next  = omask_reg;
        orem_next   = orem_reg;
        ostat_next  = ostat_reg;
        h_we    = 1'b0;
        h_waddr = slot_reg;
        h_wdata = subj_reg;
        s_we    = 1'b0;
        s_waddr = tbt_pkg::stamp_addr(slot_reg, sub_reg);
        s_wdata = 32'd0;

        if (cfg_we)
        begin
            empty_next = cfg_data;
        end

        // The output register empties when its item is taken.
        if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = req_type;
                    subj_next = subject;
                    verb_next = verb[VW-1:0];
                    now_next  = now;
                    age_next  = max_age;
                    idx_next  = '0;
                    sub_next  = '0;
                    kept_next = '0;
                    mask_next = 8'd0;
                    rem_next  = 6'd0;
                    stat_next = tbt_pkg::ST_DONE;
                    if (req_type == tbt_pkg::REQ_COMMIT)
                    begin
                        state_next = S_CMT_CHK;
                    end
                    else if ((subject == empty_reg) ||
                             ((req_type == tbt_pkg::REQ_RECORD) &&
                              (verb >= 8'(tbt_pkg::VERBS))))
                    begin
                        stat_next  = tbt_pkg::ST_REJECTED;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
            end

            S_SRCH_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    // Subject not stored.
                    if (req_reg != tbt_pkg::REQ_RECORD)
                    begin
                        state_next = S_DONE;
                    end
                    else if (count_reg < CW'(tbt_pkg::TABLE_ENTRIES))
                    begin
                        slot_next  = count_reg[IW-1:0];
                        count_next = count_reg + 1'b1;
                        stat_next  = tbt_pkg::ST_INSERTED;
                        state_next = S_CLR;
                    end
                    else
                    begin
                        stat_next   = tbt_pkg::ST_EVICTED;
                        idx_next    = '0;
                        newest_next = 32'd0;
                        state_next  = S_VICT_RD;
                    end
                end
                else
                begin
                    state_next = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP:
            begin
                if (h_rdata == subj_reg)
                begin
                    slot_next = idx_lo;
                    unique case (req_reg)
                        tbt_pkg::REQ_RECORD: state_next = S_UPD_RD;
                        tbt_pkg::REQ_QUERY:  state_next = S_QRY_RD;
                        default:
                        begin
                            mark_next[idx_lo] = 1'b1;
                            state_next        = S_DONE;
                        end
                    endcase
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SRCH_RD;
                end
            end

            S_VICT_RD:
            begin
                state_next = S_VICT_CMP;
            end

            S_VICT_CMP:
            begin
                newest_next = newest_cur;
                state_next  = S_VICT_RD;
                if (last_verb)
                begin
                    // Entry done: keep the first strictly oldest one.
                    newest_next = 32'd0;
                    sub_next    = '0;
                    best_next   = best_reg;
                    if ((idx_reg == '0) || (newest_cur < oldest_reg))
                    begin
                        oldest_next = newest_cur;
                        best_next   = idx_lo;
                    end
                    if (idx_reg == CW'(tbt_pkg::TABLE_ENTRIES - 1))
                    begin
                        slot_next  = best_next;
                        state_next = S_CLR;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    sub_next = sub_reg + 1'b1;
                end
            end

            S_CLR:
            begin
                // Zero the slot's stamps, then store the new handle.
                s_we    = 1'b1;
                s_waddr = tbt_pkg::stamp_addr(slot_reg, sub_reg);
                s_wdata = 32'd0;
                if (last_verb)
                begin
                    h_we                = 1'b1;
                    mark_next[slot_reg] = 1'b0;
                    sub_next            = '0;
                    state_next          = S_UPD_RD;
                end
                else
                begin
                    sub_next = sub_reg + 1'b1;
                end
            end

            S_UPD_RD:
            begin
                state_next = S_UPD_CMP;
            end

            S_UPD_CMP:
            begin
                // Stamps only ever move forward.
                s_waddr    = tbt_pkg::stamp_addr(slot_reg, verb_reg);
                s_wdata    = now_reg;
                s_we       = (now_reg > s_rdata);
                state_next = S_DONE;
            end

            S_QRY_RD:
            begin
                state_next = S_QRY_CMP;
            end

            S_QRY_CMP:
            begin
                mask_next[sub_reg] = fresh;
                if (last_verb)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = S_QRY_RD;
                end
            end

            S_CMT_CHK:
            begin
                if (idx_reg == count_reg)
                begin
                    rem_next   = 6'(count_reg - kept_reg);
                    count_next = kept_reg;
                    mark_next  = '0;
                    state_next = S_DONE;
                end
                else if (mark_reg[idx_lo])
                begin
                    if (kept_reg != idx_reg)
                    begin
                        state_next = S_CMT_HRD;
                    end
                    else
                    begin
                        kept_next = kept_reg + 1'b1;
                        idx_next  = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_CMT_HRD:
            begin
                state_next = S_CMT_HWR;
            end

            S_CMT_HWR:
            begin
                h_we       = 1'b1;
                h_waddr    = kept_reg[IW-1:0];
                h_wdata    = h_rdata;
                sub_next   = '0;
                state_next = S_CMT_SRD;
            end

            S_CMT_SRD:
            begin
                state_next = S_CMT_SWR;
            end

            S_CMT_SWR:
            begin
                // Move one stamp down to the kept slot.
                s_we    = 1'b1;
                s_waddr = tbt_pkg::stamp_addr(kept_reg[IW-1:0], sub_reg);
                s_wdata = s_rdata;
                if (last_verb)
                begin
                    sub_next   = '0;
                    kept_next  = kept_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_CMT_CHK;
                end
                else
                begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = S_CMT_SRD;
                end
            end

            S_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!ovalid_reg || !out_stall)
                begin
                    ovalid_next = 1'b1;
                    omask_next  = mask_reg;
                    orem_next   = rem_reg;
                    ostat_next  = stat_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            empty_reg  <= 32'hFFFF_FFFF;
            count_reg  <= '0;
            mark_reg   <= '0;
            ovalid_reg <= 1'b0;
            omask_reg  <= 8'd0;
            orem_reg   <= 6'd0;
            ostat_reg  <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            empty_reg  <= empty_next;
            count_reg  <= count_next;
            mark_reg   <= mark_next;
            ovalid_reg <= ovalid_next;
            omask_reg  <= omask_next;
            orem_reg   <= orem_next;
            ostat_reg  <= ostat_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        subj_reg   <= subj_next;
        verb_reg   <= verb_next;
        now_reg    <= now_next;
        age_reg    <= age_next;
        idx_reg    <= idx_next;
        sub_reg    <= sub_next;
        slot_reg   <= slot_next;
        best_reg   <= best_next;
        newest_reg <= newest_next;
        oldest_reg <= oldest_next;
        kept_reg   <= kept_next;
        mask_reg   <= mask_next;
        rem_reg    <= rem_next;
        stat_reg   <= stat_next;
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// Timestamped belief table testbench
// Drives record, query, mark and commit requests through the valid/stall
// channels and checks every result against an in-bench table model that is
// updated as each item is accepted. The empty handle is changed between
// phases; the sender and receiver idle at different rates in the first two phases.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        tbt_pkg::req_t kind;
        logic [31:0]   subj;
        logic [7:0]    vb;
        logic [31:0]   tnow;
        logic [31:0]   age;
    } request_t;

    typedef struct {
        logic [7:0]       mask;
        logic [5:0]       dropped;
        tbt_pkg::status_t st;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  req_type;
    logic [31:0] subject;
    logic [7:0]  verb;
    logic [31:0] now;
    logic [31:0] max_age;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  belief_mask;
    logic [5:0]  removed_count;
    logic [1:0]  status;

    timestamped_belief_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .subject       (subject),
        .verb          (verb),
        .now           (now),
        .max_age       (max_age),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .belief_mask   (belief_mask),
        .removed_count (removed_count),
        .status        (status)
    );

    // Table model state.
    logic [31:0] tbl_empty;
    logic [31:0] tbl_handle [tbt_pkg::TABLE_ENTRIES];
    logic [31:0] tbl_stamp  [tbt_pkg::TABLE_ENTRIES][tbt_pkg::VERBS];
    logic        tbl_alive  [tbt_pkg::TABLE_ENTRIES];
    int          tbl_count;

    request_t    pending_reqs[$];
    answer_t     expected_answers[$];
    int          error_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic [31:0] tick;
    logic [31:0] handle_pool [44];

    // Clock.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp);
        error_count++;
    endtask

    function automatic void wipe_slot(input int k);
        tbl_handle[k] = tbl_empty;
        for (int v = 0; v < tbt_pkg::VERBS; v++)
            tbl_stamp[k][v] = '0;
        tbl_alive[k] = 1'b0;
    endfunction

    function automatic int lookup_slot(input logic [31:0] h);
        for (int k = 0; k < tbl_count; k++)
            if (tbl_handle[k] == h)
                return k;
        return -1;
    endfunction

    // First entry whose newest stamp is strictly the oldest.
    function automatic int oldest_slot();
        int          best;
        logic [31:0] oldest;
        logic [31:0] newest;
        best = 0;
        oldest = '0;
        for (int j = 0; j < tbt_pkg::TABLE_ENTRIES; j++)
        begin
            newest = '0;
            for (int v = 0; v < tbt_pkg::VERBS; v++)
                if (tbl_stamp[j][v] > newest)
                    newest = tbl_stamp[j][v];
            if (j == 0 || newest < oldest)
            begin
                oldest = newest;
                best = j;
            end
        end
        return best;
    endfunction

    // Applies one request to the table model and returns its answer.
    function automatic answer_t apply_request(input request_t r);
        answer_t     a;
        int          k;
        int          kept;
        logic [31:0] s;
        a.mask = '0;
        a.dropped = '0;
        a.st = tbt_pkg::ST_DONE;
        case (r.kind)
            tbt_pkg::REQ_RECORD:
            begin
                if (r.subj == tbl_empty || r.vb >= tbt_pkg::VERBS)
                    a.st = tbt_pkg::ST_REJECTED;
                else
                begin
                    k = lookup_slot(r.subj);
                    if (k < 0)
                    begin
                        if (tbl_count < tbt_pkg::TABLE_ENTRIES)
                        begin
                            k = tbl_count;
                            tbl_count++;
                            a.st = tbt_pkg::ST_INSERTED;
                        end
                        else
                        begin
                            k = oldest_slot();
                            a.st = tbt_pkg::ST_EVICTED;
                        end
                        wipe_slot(k);
                        tbl_handle[k] = r.subj;
                    end
                    if (r.tnow > tbl_stamp[k][r.vb])
                        tbl_stamp[k][r.vb] = r.tnow;
                end
            end
            tbt_pkg::REQ_QUERY:
            begin
                if (r.subj == tbl_empty)
                    a.st = tbt_pkg::ST_REJECTED;
                else
                begin
                    k = lookup_slot(r.subj);
                    if (k >= 0)
                        for (int v = 0; v < tbt_pkg::VERBS; v++)
                        begin
                            s = tbl_stamp[k][v];
                            if (s != 0 && (r.age == 0 || r.tnow < s || r.tnow - s <= r.age))
                                a.mask[v] = 1'b1;
                        end
                end
            end
            tbt_pkg::REQ_MARK:
            begin
                if (r.subj == tbl_empty)
                    a.st = tbt_pkg::ST_REJECTED;
                else
                begin
                    k = lookup_slot(r.subj);
                    if (k >= 0)
                        tbl_alive[k] = 1'b1;
                end
            end
            default:
            begin
                kept = 0;
                for (int j = 0; j < tbl_count; j++)
                    if (tbl_alive[j])
                    begin
                        tbl_handle[kept] = tbl_handle[j];
                        tbl_stamp[kept] = tbl_stamp[j];
                        kept++;
                    end
                for (int j = kept; j < tbt_pkg::TABLE_ENTRIES; j++)
                    wipe_slot(j);
                for (int j = 0; j < tbt_pkg::TABLE_ENTRIES; j++)
                    tbl_alive[j] = 1'b0;
                a.dropped = 6'(tbl_count - kept);
                tbl_count = kept;
            end
        endcase
        return a;
    endfunction

    // Driver: accepted items go through the model, then the next item or a gap.
    always @(posedge clk)
    begin
        request_t r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                r.kind = tbt_pkg::req_t'(req_type);
                r.subj = subject;
                r.vb = verb;
                r.tnow = now;
                r.age = max_age;
                expected_answers.push_back(apply_request(r));
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() == 0 || $urandom_range(0, 99) < send_idle_pct)
                    in_valid <= 1'b0;
                else
                begin
                    r = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= r.kind;
                    subject <= r.subj;
                    verb <= r.vb;
                    now <= r.tnow;
                    max_age <= r.age;
                end
            end
        end
    end

    // Monitor: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        answer_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected result", 32'(belief_mask), 32'b0);
                else
                begin
                    e = expected_answers.pop_front();
                    if (belief_mask !== e.mask)
                        report_mismatch("belief_mask", 32'(belief_mask), 32'(e.mask));
                    if (removed_count !== e.dropped)
                        report_mismatch("removed_count", 32'(removed_count),
                                        32'(e.dropped));
                    if (status !== e.st)
                        report_mismatch("status", 32'(status), 32'(e.st));
                end
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic queue_item(input tbt_pkg::req_t kind, input logic [31:0] subj,
                              input logic [7:0] vb, input logic [31:0] tnow,
                              input logic [31:0] age);
        request_t r;
        r.kind = kind;
        r.subj = subj;
        r.vb = vb;
        r.tnow = tnow;
        r.age = age;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] pick_subject();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return handle_pool[$urandom_range(0, 43)];
    endfunction

    function automatic logic [31:0] pick_time();
        int p;
        p = $urandom_range(0, 99);
        tick = tick + $urandom_range(0, 50);
        if (p < 5)
            return '0;
        if (p < 10)
            return $urandom;
        if (p < 15)
            return '1;
        return tick;
    endfunction

    function automatic logic [31:0] pick_age();
        int p;
        p = $urandom_range(0, 9);
        if (p < 2)
            return '0;
        if (p < 6)
            return $urandom_range(1, 100);
        if (p < 8)
            return $urandom;
        return '1;
    endfunction

    function automatic logic [7:0] pick_verb();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, tbt_pkg::VERBS - 1));
    endfunction

    // Random mix: records and queries, mark runs closed by a commit, some noise.
    task automatic queue_random(input int target);
        int added;
        int p;
        int marks;
        added = 0;
        while (added < target)
        begin
            p = $urandom_range(0, 99);
            if (p < 50)
            begin
                queue_item(tbt_pkg::REQ_RECORD, pick_subject(), pick_verb(), pick_time(),
                           pick_age());
                added++;
            end
            else if (p < 75)
            begin
                queue_item(tbt_pkg::REQ_QUERY, pick_subject(), pick_verb(), pick_time(),
                           pick_age());
                added++;
            end
            else if (p < 90)
            begin
                marks = $urandom_range(0, 20);
                for (int i = 0; i < marks; i++)
                    queue_item(tbt_pkg::REQ_MARK, pick_subject(), pick_verb(), pick_time(),
                               pick_age());
                queue_item(tbt_pkg::REQ_COMMIT, pick_subject(), pick_verb(), pick_time(),
                           pick_age());
                added += marks + 1;
            end
            else
            begin
                queue_item(p < 96 ? tbt_pkg::REQ_MARK : tbt_pkg::REQ_COMMIT, pick_subject(),
                           pick_verb(), pick_time(), pick_age());
                added++;
            end
        end
    endtask

    // Waits until every item is accepted and every result has come back.
    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_empty_handle(input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        tbl_empty = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sequencer: reset, directed checks, then three randomized phases.
    initial
    begin
        logic [31:0] phase_cfg [3];
        int          phase_send [3];
        int          phase_recv [3];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = '0;
        subject = '0;
        verb = '0;
        now = '0;
        max_age = '0;
        out_stall = 1'b0;
        error_count = 0;
        tick = 32'd1000;
        tbl_empty = '1;
        tbl_count = 0;
        for (int k = 0; k < tbt_pkg::TABLE_ENTRIES; k++)
            wipe_slot(k);
        handle_pool[0] = '0;
        handle_pool[1] = '1;
        handle_pool[2] = 32'h8000_0000;
        handle_pool[3] = 32'h7FFF_FFFF;
        for (int i = 4; i < 44; i++)
            handle_pool[i] = $urandom;
        phase_cfg[0] = '1;
        phase_cfg[1] = '0;
        phase_cfg[2] = handle_pool[$urandom_range(4, 43)];
        phase_send = '{11, 87, 0};
        phase_recv = '{87, 11, 0};
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 3; ph++)
        begin
            write_empty_handle(phase_cfg[ph]);
            send_idle_pct = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            if (ph == 0)
            begin
                // Commit on an empty table, rejects, extreme fields.
                queue_item(tbt_pkg::REQ_COMMIT, '0, '0, '0, '0);
                queue_item(tbt_pkg::REQ_RECORD, '1, 8'd0, 32'd5, '0);
                queue_item(tbt_pkg::REQ_RECORD, 32'd10, 8'd8, 32'd5, '0);
                queue_item(tbt_pkg::REQ_RECORD, 32'd10, 8'hFF, 32'd5, '0);
                queue_item(tbt_pkg::REQ_RECORD, '0, 8'd0, 32'd100, '0);
                queue_item(tbt_pkg::REQ_RECORD, '0, 8'd7, '1, '0);
                queue_item(tbt_pkg::REQ_RECORD, 32'd10, 8'd3, '0, '0);
                queue_item(tbt_pkg::REQ_RECORD, 32'd10, 8'd3, 32'd200, '0);
                queue_item(tbt_pkg::REQ_RECORD, 32'd10, 8'd3, 32'd150, '0);
                // Freshness: never expire, in window, expired, future stamp.
                queue_item(tbt_pkg::REQ_QUERY, '0, '0, 32'd150, '0);
                queue_item(tbt_pkg::REQ_QUERY, '0, '0, 32'd150, 32'd50);
                queue_item(tbt_pkg::REQ_QUERY, 32'd10, '0, 32'd260, 32'd50);
                queue_item(tbt_pkg::REQ_QUERY, 32'd10, '0, 32'd250, 32'd50);
                queue_item(tbt_pkg::REQ_QUERY, '0, '0, '1, '1);
                queue_item(tbt_pkg::REQ_QUERY, 32'd77, '0, 32'd1, '0);
                queue_item(tbt_pkg::REQ_QUERY, '1, '0, 32'd1, '0);
                // Marks on known, unknown and empty handles, then commit.
                queue_item(tbt_pkg::REQ_MARK, 32'd10, '0, '0, '0);
                queue_item(tbt_pkg::REQ_MARK, 32'd77, '0, '0, '0);
                queue_item(tbt_pkg::REQ_MARK, '1, '0, '0, '0);
                queue_item(tbt_pkg::REQ_RECORD, 32'd20, 8'd1, 32'd300, '0);
                queue_item(tbt_pkg::REQ_COMMIT, '1, '1, '1, '1);
                queue_item(tbt_pkg::REQ_QUERY, 32'd10, '0, 32'd300, '0);
                queue_item(tbt_pkg::REQ_QUERY, '0, '0, 32'd300, '0);
                drain();
            end
            queue_random(460);
            drain();
        end

        if (error_count == 0)
            $display("timestamped_belief_table test passed");
        else
            $display("timestamped_belief_table test failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #40_000_000;
        $display("timestamped_belief_table test failed");
        $finish;
    end

endmodule
